// File: rtl/hnps_pkg.sv
// Package: shared types and constants for the held-note priority stack.
`timescale 1ns / 1ps
package hnps_pkg;

  localparam logic [7:0] EMPTY_KEY = 8'hFF;

  typedef enum logic [1:0] {
    KIND_PRESS   = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_READ    = 2'd2,
    KIND_NONE    = 2'd3
  } kind_t;

  // Operands broadcast to every cell.
  typedef struct packed {
    logic [7:0] key;
    logic [2:0] index;
  } cmd_t;

  // Shift controls, resolved after the match chain settles.
  typedef struct packed {
    logic push;
    logic pop;
  } ctl_t;

endpackage

// File: rtl/hnps_cell.sv
// One slot cell of the priority stack: holds a key, compares, shifts.
`timescale 1ns / 1ps
module hnps_cell
  import hnps_pkg::*;
#(
  parameter int IDX = 0,
  parameter int CW  = 4
) (
  input  logic          clk,
  input  cmd_t          cmd,
  input  ctl_t          ctl,
  input  logic [CW-1:0] count,
  input  logic [7:0]    prev_key,
  input  logic [7:0]    next_key,
  input  logic          hit_in,
  output logic          hit_out,
  input  logic [7:0]    rd_in,
  output logic [7:0]    rd_out,
  output logic [7:0]    key_out
);

  logic [7:0] key_r;
  logic [7:0] key_nxt;
  logic       valid;
  logic       sel;

  assign valid   = 32'(count) > IDX;
  assign sel     = valid && (32'(cmd.index) == IDX);
  assign hit_out = hit_in | (valid && (key_r == cmd.key));
  assign rd_out  = rd_in | (sel ? key_r : 8'd0);
  assign key_out = key_r;

  // push: take from the slot above; pop: cells at or below the match close the gap
  always_comb begin
    key_nxt = key_r;
    if (ctl.push) begin
      key_nxt = prev_key;
    end else if (ctl.pop && hit_out) begin
      key_nxt = next_key;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

endmodule

// File: rtl/held_note_priority_stack_unit.sv
// Top level: held-note priority stack built as a row of slot cells.
`timescale 1ns / 1ps
// Keeps the held keys in most-recent-first order, one key per cell in a row
// of DEPTH cells. A command transfers when start is high and busy is low;
// busy never rises, so one command can transfer every clock cycle. Each
// command gives exactly one result, on the out_ ports for one cycle with
// out_valid high, in the cycle after the transfer; the receiver cannot
// stall it. A press pushes a new key into cell 0 and moves the rest one cell
// down (dropped if the key is held or all cells are full); a release removes
// the matching key and pulls the cells behind it up by one; a read returns
// the key at the given slot, or 255 when that slot is empty. The per-cycle
// rate is set by the key-match chain that runs through all cells.
module held_note_priority_stack_unit
  import hnps_pkg::*;
#(
  parameter int DEPTH = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] in_kind,
  input  logic [7:0] in_key,
  input  logic [2:0] in_index,
  output logic       out_valid,
  output logic [7:0] out_read_key,
  output logic [3:0] out_held_count
);

  localparam int CW = $clog2(DEPTH + 1);

  logic          accept;
  cmd_t          cmd;
  ctl_t          ctl;
  kind_t         kind;
  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;
  logic          full;
  logic          read_hit;
  logic [7:0]    read_key;
  logic [31:0]   count_ext;

  logic          valid_r;
  logic [7:0]    read_key_r;
  logic [3:0]    held_r;

  logic [7:0]    key_w [DEPTH];
  logic          hit_w [DEPTH+1];
  logic [7:0]    rd_w  [DEPTH+1];

  // commands never stall: busy is tied low
  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign kind   = kind_t'(in_kind);

  assign cmd.key   = in_key;
  assign cmd.index = in_index;

  assign hit_w[0] = 1'b0;
  assign rd_w[0]  = 8'd0;

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      logic [7:0] prev_k;
      logic [7:0] next_k;
      if (g == 0) begin : g_head
        assign prev_k = in_key;
      end else begin : g_body
        assign prev_k = key_w[g-1];
      end
      // last cell refills from itself; that slot drops out of the count
      if (g == DEPTH - 1) begin : g_tail
        assign next_k = key_w[g];
      end else begin : g_mid
        assign next_k = key_w[g+1];
      end

      hnps_cell #(
        .IDX(g),
        .CW (CW)
      ) u_cell (
        .clk     (clk),
        .cmd     (cmd),
        .ctl     (ctl),
        .count   (count_r),
        .prev_key(prev_k),
        .next_key(next_k),
        .hit_in  (hit_w[g]),
        .hit_out (hit_w[g+1]),
        .rd_in   (rd_w[g]),
        .rd_out  (rd_w[g+1]),
        .key_out (key_w[g])
      );
    end
  endgenerate

  // hit_w[DEPTH] is high when the key is already held
  assign full     = 32'(count_r) >= DEPTH;
  assign ctl.push = accept && (kind == KIND_PRESS) && !hit_w[DEPTH] && !full;
  assign ctl.pop  = accept && (kind == KIND_RELEASE) && hit_w[DEPTH];

  always_comb begin
    count_nxt = count_r;
    if (ctl.push) begin
      count_nxt = count_r + CW'(1);
    end else if (ctl.pop) begin
      count_nxt = count_r - CW'(1);
    end
  end

  // only one cell can select, so the OR chain is the slot mux
  assign read_hit  = (kind == KIND_READ) && (32'(in_index) < 32'(count_r));
  assign read_key  = read_hit ? rd_w[DEPTH] : EMPTY_KEY;
  assign count_ext = 32'(count_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      valid_r <= accept;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      read_key_r <= read_key;
      held_r     <= count_ext[3:0];
    end
  end

  assign out_valid      = valid_r;
  assign out_read_key   = read_key_r;
  assign out_held_count = held_r;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= DEPTH)
    else $error("held count exceeds depth");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid)
    else $error("transfer without result");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> !out_valid)
    else $error("result without transfer");

  a_dup_press: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (kind == KIND_PRESS) && hit_w[DEPTH]) |=> $stable(count_r))
    else $error("press of held key changed count");

  a_push_pop_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctl.push && ctl.pop))
    else $error("push and pop together");
`endif

endmodule

// File: dv/tb.sv
// Testbench for held_note_priority_stack_unit: directed and random key events, checked per result.
`timescale 1ns / 1ps
module tb;
  import hnps_pkg::*;

  localparam int STACK_DEPTH = 8;
  localparam int IDLE_LIMIT  = 2000;  // cycles with no transfer and no result
  localparam int TAIL_CYCLES = 8;     // settle time after the last result

  // One expected result, same layout as the out_ ports.
  typedef struct packed {
    logic [7:0] read_key;
    logic [3:0] held_count;
  } note_result_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  logic [1:0] in_kind = 2'd0;
  logic [7:0] in_key = 8'd0;
  logic [2:0] in_index = 3'd0;
  logic       out_valid;
  logic [7:0] out_read_key;
  logic [3:0] out_held_count;

  // Mirror of the held-key list, slot 0 most recent.
  logic [7:0]   held_keys[STACK_DEPTH];
  int           held_n = 0;
  note_result_t pending_results[$];
  int           fail_cnt = 0;
  int           idle_cycles = 0;
  bit           burst_mode = 1'b0;

  held_note_priority_stack_unit #(
    .DEPTH(STACK_DEPTH)
  ) u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_kind       (in_kind),
    .in_key        (in_key),
    .in_index      (in_index),
    .out_valid     (out_valid),
    .out_read_key  (out_read_key),
    .out_held_count(out_held_count)
  );

  always #6 clk = ~clk;

  // Apply one key event to the mirror list and return the result it gives.
  function automatic note_result_t apply_key_event(kind_t kind, logic [7:0] key,
                                                   logic [2:0] index);
    note_result_t r;
    int pos;
    r.read_key = EMPTY_KEY;
    pos = -1;
    for (int i = 0; i < held_n; i++) begin
      if (pos < 0 && held_keys[i] == key) pos = i;
    end
    case (kind)
      KIND_PRESS: begin
        // a held key or a full list leaves everything as it is
        if (pos < 0 && held_n < STACK_DEPTH) begin
          for (int i = held_n; i > 0; i--) held_keys[i] = held_keys[i-1];
          held_keys[0] = key;
          held_n++;
        end
      end
      KIND_RELEASE: begin
        // close the gap, keeping the order of the rest
        if (pos >= 0) begin
          for (int i = pos; i + 1 < held_n; i++) held_keys[i] = held_keys[i+1];
          held_n--;
        end
      end
      KIND_READ: begin
        if (int'(index) < held_n) r.read_key = held_keys[index];
      end
      default: ;  // unused kind: no change, read_key stays empty
    endcase
    r.held_count = 4'(held_n);
    return r;
  endfunction

  // Mostly back-to-back, some short gaps, a few long ones.
  function automatic int pick_gap();
    int r;
    if (burst_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Drive one command, hold it until the transfer, then record the expectation.
  // Called at a rising edge; start stays high when no gap follows.
  task automatic send_key_event(kind_t kind, logic [7:0] key, logic [2:0] index);
    int gap;
    start    <= 1'b1;
    in_kind  <= kind;
    in_key   <= key;
    in_index <= index;
    do @(posedge clk); while (busy);
    pending_results.push_back(apply_key_event(kind, key, index));
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Sender holds off until every outstanding result has arrived.
  task automatic wait_for_results();
    start <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // Empty list: reads anywhere are empty, unused kind reports count zero.
  task automatic test_empty_list();
    send_key_event(KIND_READ, 8'h00, 3'd0);
    send_key_event(KIND_READ, 8'hFF, 3'd7);
    send_key_event(KIND_NONE, 8'hA5, 3'd5);
  endtask

  // Fill to full with the extreme keys; duplicate press and press when full are dropped.
  task automatic test_fill_and_overflow();
    send_key_event(KIND_PRESS, 8'h00, 3'd0);
    send_key_event(KIND_PRESS, 8'hFF, 3'd0);  // key 255 is stored like any other
    send_key_event(KIND_PRESS, 8'h55, 3'd7);
    send_key_event(KIND_PRESS, 8'h55, 3'd0);  // already held
    send_key_event(KIND_PRESS, 8'hAA, 3'd0);
    send_key_event(KIND_PRESS, 8'h01, 3'd0);
    send_key_event(KIND_PRESS, 8'hFE, 3'd0);
    send_key_event(KIND_PRESS, 8'h80, 3'd0);
    send_key_event(KIND_PRESS, 8'h7F, 3'd0);
    send_key_event(KIND_PRESS, 8'h09, 3'd0);  // list full
    send_key_event(KIND_READ, 8'h00, 3'd0);
    send_key_event(KIND_READ, 8'h00, 3'd7);
    send_key_event(KIND_READ, 8'h00, 3'd6);   // slot holding key 255
  endtask

  // Releases from the middle, the oldest slot, of key 255, and of a key not held.
  task automatic test_release();
    send_key_event(KIND_RELEASE, 8'h55, 3'd0);
    send_key_event(KIND_RELEASE, 8'h03, 3'd0);  // not held
    send_key_event(KIND_RELEASE, 8'hFF, 3'd0);
    send_key_event(KIND_RELEASE, 8'h00, 3'd0);
    send_key_event(KIND_READ, 8'h00, 3'd4);
    send_key_event(KIND_READ, 8'h00, 3'd5);     // just past the count
    send_key_event(KIND_NONE, 8'h00, 3'd2);
    wait_for_results();
  endtask

  // Random play: mostly events on a small key set so the list fills and drains,
  // with some arbitrary keys and unused kinds as noise.
  task automatic test_random_play(int n_items);
    int         r;
    kind_t      kind;
    logic [7:0] key;
    logic [7:0] key_base;
    key_base = 8'($urandom_range(0, 243));
    for (int n = 0; n < n_items; n++) begin
      if (n % 100 == 0) begin
        burst_mode = ($urandom_range(0, 3) == 0);
        key_base   = 8'($urandom_range(0, 243));
      end
      if (n % 400 == 399) wait_for_results();
      r = $urandom_range(0, 99);
      if (r < 40)      kind = KIND_PRESS;
      else if (r < 70) kind = KIND_RELEASE;
      else if (r < 95) kind = KIND_READ;
      else             kind = KIND_NONE;
      r = $urandom_range(0, 99);
      if (kind == KIND_RELEASE && held_n > 0 && r < 60)
        key = held_keys[$urandom_range(0, held_n - 1)];
      else if (r < 85)
        key = key_base + 8'($urandom_range(0, 11));
      else
        key = 8'($urandom_range(0, 255));
      send_key_event(kind, key, 3'($urandom_range(0, 7)));
    end
    wait_for_results();
  endtask

  // Every result transfers on the edge that ends its out_valid cycle; check it
  // against the oldest outstanding expectation.
  always @(posedge clk) begin
    note_result_t exp_r;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: read_key %0d held_count %0d",
               out_read_key, out_held_count);
        fail_cnt++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_read_key !== exp_r.read_key) begin
          $error("read_key: expected %0d, actual %0d", exp_r.read_key, out_read_key);
          fail_cnt++;
        end
        if (out_held_count !== exp_r.held_count) begin
          $error("held_count: expected %0d, actual %0d", exp_r.held_count, out_held_count);
          fail_cnt++;
        end
      end
    end
  end

  // Watchdog: too many cycles without a command transfer or a result.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("** held_note_priority_stack_unit: FAILED **");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_list();
    test_fill_and_overflow();
    test_release();
    test_random_play(1700);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_cnt == 0 && pending_results.size() == 0) begin
      $display("** held_note_priority_stack_unit: PASSED **");
    end else begin
      if (pending_results.size() != 0)
        $error("%0d expected results never arrived", pending_results.size());
      $display("** held_note_priority_stack_unit: FAILED **");
    end
    $finish;
  end

endmodule
